>>> hdl/anps_pkg.sv
`timescale 1ns / 1ps
package anps_pkg;

    localparam logic [7:0] OP_ADD   = 8'd43;
    localparam logic [7:0] OP_SUB   = 8'd45;
    localparam logic [7:0] OP_MUL   = 8'd42;
    localparam logic [7:0] OP_DIV   = 8'd47;
    localparam logic [7:0] OP_PRIME = 8'd112;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_UNKNOWN  = 2'd3;

    localparam int QUEUE_DEPTH_DEF = 2;

    typedef struct packed {
        logic [7:0]         req_type;
        logic signed [31:0] operand_b;
        logic signed [15:0] operand_c;
    } req_t;

    typedef struct packed {
        logic signed [31:0] answer;
        logic [1:0]         status;
    } rsp_t;

    typedef enum logic [2:0] {
        OPC_ADD,
        OPC_SUB,
        OPC_MUL,
        OPC_DIV,
        OPC_PRIME,
        OPC_UNKNOWN
    } opc_t;

    typedef struct packed {
        opc_t               opc;
        logic signed [31:0] b;
        logic signed [15:0] c;
    } job_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
        logic [31:0] remainder;
    } div_rsp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV_WAIT,
        S_PR_CAND,
        S_PR_DIV,
        S_DONE
    } state_t;

endpackage

>>> hdl/anps_front.sv
`timescale 1ns / 1ps
module anps_front
    import anps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic job_valid,
    input  logic job_take,
    output job_t job
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    job_t          q_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    job_t          job_in;
    logic          do_wr;
    logic          do_rd;

    // Classify the opcode on the way in
    always_comb
    begin
        job_in.b = req.operand_b;
        job_in.c = req.operand_c;
        case (req.req_type)
            OP_ADD:   job_in.opc = OPC_ADD;
            OP_SUB:   job_in.opc = OPC_SUB;
            OP_MUL:   job_in.opc = OPC_MUL;
            OP_DIV:   job_in.opc = OPC_DIV;
            OP_PRIME: job_in.opc = OPC_PRIME;
            default:  job_in.opc = OPC_UNKNOWN;
        endcase
    end

    assign full      = (count_reg == FULL_CNT);
    assign job_valid = (count_reg != '0);
    assign job       = q_reg[rd_ptr_reg];
    assign do_wr     = push && !full;
    assign do_rd     = job_take && job_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

>>> hdl/anps_divu.sv
`timescale 1ns / 1ps
module anps_divu
    import anps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t dreq,
    output div_rsp_t drsp
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;
    logic [32:0] trial;

    // One quotient bit a cycle, restoring
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[31]};
        trial     = shifted - {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (dreq.start)
        begin
            rem_next = '0;
            quo_next = dreq.dividend;
            dsr_next = dreq.divisor;
            cnt_next = 6'd32;
        end
        else if (cnt_reg != '0)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign drsp.done      = done_reg;
    assign drsp.quotient  = quo_reg;
    assign drsp.remainder = rem_reg;

endmodule

>>> hdl/anps_back.sv
`timescale 1ns / 1ps
module anps_back
    import anps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     job_valid,
    output logic     job_take,
    input  job_t     job,
    output div_req_t dreq,
    input  div_rsp_t drsp,
    output logic     empty,
    input  logic     pop,
    output rsp_t     rsp
);

    state_t      state_reg, state_next;
    opc_t        opc_reg, opc_next;
    logic [31:0] b_reg, b_next;
    logic [15:0] c_reg, c_next;
    logic [31:0] x_reg, x_next;
    logic [15:0] found_reg, found_next;
    logic [16:0] d_reg, d_next;
    logic [32:0] sq_reg, sq_next;
    logic        neg_reg, neg_next;
    logic [31:0] ans_reg, ans_next;
    logic [1:0]  st_reg, st_next;
    rsp_t        res_reg, res_next;
    logic        res_valid_reg, res_valid_next;

    logic [31:0] c_ext;
    logic [31:0] mag_b;
    logic [31:0] mag_c;
    logic [31:0] mul_lo;
    logic        is_prime;
    logic        is_comp;
    logic        slot_free;

    assign c_ext     = {{16{c_reg[15]}}, c_reg};
    assign mag_b     = b_reg[31] ? (~b_reg + 1'b1) : b_reg;
    assign mag_c     = c_ext[31] ? (~c_ext + 1'b1) : c_ext;
    assign mul_lo    = b_reg * c_ext;
    assign slot_free = !res_valid_reg || pop;

    // Candidate classification without a division
    always_comb
    begin
        is_prime = 1'b0;
        is_comp  = 1'b0;
        if (x_reg == 32'd2)
        begin
            is_prime = 1'b1;
        end
        else if (!x_reg[0])
        begin
            is_comp = 1'b1;
        end
        else if (sq_reg > {1'b0, x_reg})
        begin
            is_prime = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (opc_reg == OPC_DIV && c_reg != '0
                    && !(b_reg == 32'h8000_0000 && c_reg == 16'hFFFF))
                begin
                    state_next = S_DIV_WAIT;
                end
                else if (opc_reg == OPC_PRIME && !c_reg[15])
                begin
                    state_next = S_PR_CAND;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV_WAIT:
            begin
                if (drsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_PR_CAND:
            begin
                if (x_reg[31])
                begin
                    state_next = S_DONE;
                end
                else if (is_prime && found_reg == c_reg)
                begin
                    state_next = S_DONE;
                end
                else if (!is_prime && !is_comp)
                begin
                    state_next = S_PR_DIV;
                end
            end
            S_PR_DIV:
            begin
                if (drsp.done)
                begin
                    state_next = S_PR_CAND;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        opc_next       = opc_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        x_next         = x_reg;
        found_next     = found_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        neg_next       = neg_reg;
        ans_next       = ans_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !pop;
        job_take       = 1'b0;
        dreq.start     = 1'b0;
        dreq.dividend  = mag_b;
        dreq.divisor   = mag_c;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    job_take = 1'b1;
                    opc_next = job.opc;
                    b_next   = job.b;
                    c_next   = job.c;
                end
            end
            S_EXEC:
            begin
                ans_next   = '0;
                st_next    = ST_OK;
                x_next     = ($signed(b_reg) < 32'sd2) ? 32'd2 : b_reg;
                found_next = '0;
                d_next     = 17'd3;
                sq_next    = 33'd9;
                neg_next   = b_reg[31] ^ c_reg[15];
                case (opc_reg)
                    OPC_ADD: ans_next = b_reg + c_ext;
                    OPC_SUB: ans_next = b_reg - c_ext;
                    OPC_MUL: ans_next = mul_lo;
                    OPC_DIV:
                    begin
                        if (c_reg == '0)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else if (b_reg == 32'h8000_0000 && c_reg == 16'hFFFF)
                        begin
                            st_next = ST_OVERFLOW;
                        end
                        else
                        begin
                            dreq.start = 1'b1;
                        end
                    end
                    OPC_PRIME:
                    begin
                        if (c_reg[15])
                        begin
                            ans_next = b_reg - 1'b1;
                        end
                    end
                    default: st_next = ST_UNKNOWN;
                endcase
            end
            S_DIV_WAIT:
            begin
                ans_next = neg_reg ? (~drsp.quotient + 1'b1) : drsp.quotient;
            end
            S_PR_CAND:
            begin
                if (x_reg[31])
                begin
                    ans_next = '0;
                    st_next  = ST_OVERFLOW;
                end
                else if (is_prime || is_comp)
                begin
                    if (is_prime && found_reg == c_reg)
                    begin
                        ans_next = x_reg;
                    end
                    else
                    begin
                        if (is_prime)
                        begin
                            found_next = found_reg + 1'b1;
                        end
                        x_next  = x_reg + 1'b1;
                        d_next  = 17'd3;
                        sq_next = 33'd9;
                    end
                end
                else
                begin
                    dreq.start    = 1'b1;
                    dreq.dividend = x_reg;
                    dreq.divisor  = {15'd0, d_reg};
                end
            end
            S_PR_DIV:
            begin
                if (drsp.done)
                begin
                    if (drsp.remainder == '0)
                    begin
                        x_next  = x_reg + 1'b1;
                        d_next  = 17'd3;
                        sq_next = 33'd9;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        d_next  = d_reg + 17'd2;
                        sq_next = sq_reg + {14'd0, d_reg, 2'b00} + 33'd4;
                    end
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    res_next.answer = ans_reg;
                    res_next.status = st_reg;
                    res_valid_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        opc_reg   <= opc_next;
        b_reg     <= b_next;
        c_reg     <= c_next;
        x_reg     <= x_next;
        found_reg <= found_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        neg_reg   <= neg_next;
        ans_reg   <= ans_next;
        st_reg    <= st_next;
        res_reg   <= res_next;
    end

    assign empty = !res_valid_reg;
    assign rsp   = res_reg;

endmodule

>>> hdl/alu_with_nth_prime_search.sv
`timescale 1ns / 1ps
// Integer ALU with a trial-division prime search.
// Request side is a queue write port: drive req and raise push; the beat is
// taken on a clock edge with push high and full low. A short job queue
// (QUEUE_DEPTH entries) holds classified requests, so the sender keeps
// pushing while the execution side is busy.
// Result side is a queue read port: while empty is low, rsp holds the oldest
// result; raise pop to take the beat. One result per request, in order.
// Add, subtract, multiply and error cases go from the job queue through the
// IDLE, EXEC and DONE states into the result register; divide also waits in
// DIV_WAIT on one 32-step shift-subtract divider. Prime search: a candidate
// x is settled in PR_CAND if it is even, two, or has no odd divisor left up
// to sqrt x; else each odd trial divisor is tried in PR_DIV on the shared
// iterative divider, which sets the pace of a search.
// A stalled receiver holds the result register; the back end then parks its
// finished result, and the job queue fills until full rises.
// Reset (rst_n low, asynchronous) empties both queues and idles the engine.
module alu_with_nth_prime_search
    import anps_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    output logic full,
    input  req_t req,
    output logic empty,
    input  logic pop,
    output rsp_t rsp
);

    job_t     job;
    logic     job_valid;
    logic     job_take;
    div_req_t dreq;
    div_rsp_t drsp;

    // Accept and classify, buffer jobs
    anps_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .req       (req),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    // Shared divider for divide and trial division
    anps_divu u_divu (
        .clk   (clk),
        .rst_n (rst_n),
        .dreq  (dreq),
        .drsp  (drsp)
    );

    // Execute jobs and hold the result beat
    anps_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .dreq      (dreq),
        .drsp      (drsp),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp)
    );

endmodule
